### src/lhjt_pkg.sv
// Shared constants, codes and helpers of the linear probing hash table.
`timescale 1ns / 1ps
package lhjt_pkg;

  localparam int TABLE_DEPTH_LOG2 = 12;
  localparam int DEPTH            = 1 << TABLE_DEPTH_LOG2;
  localparam int SLOT_CNT_W       = TABLE_DEPTH_LOG2 + 1;
  localparam int MAX_MATCHES      = 64;
  localparam int IDX_W            = 7;
  localparam int KEY_W            = 31;
  localparam int VAL_W            = 31;
  localparam int CMD_W            = 2;
  localparam int STATUS_W         = 3;
  localparam int CFG_W            = 4;
  localparam int CFG_RESET        = 12;

  localparam logic [31:0] MIX_C1 = 32'h85eb_ca6b;
  localparam logic [31:0] MIX_C2 = 32'hc2b2_ae35;
  localparam int MIX_SH_A = 16;
  localparam int MIX_SH_B = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_PROBE  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_MATCH    = 3'd2,
    ST_NOMATCH  = 3'd3,
    ST_CLEARED  = 3'd4,
    ST_LIMIT    = 3'd5
  } status_t;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } slot_t;

  function automatic logic [TABLE_DEPTH_LOG2-1:0] slot_mask(input logic [CFG_W-1:0] lg);
    logic [TABLE_DEPTH_LOG2-1:0] m;
    for (int i = 0; i < TABLE_DEPTH_LOG2; i++) begin
      m[i] = (lg > CFG_W'(i));
    end
    return m;
  endfunction

endpackage

### src/lhjt_in_if.sv
// Input channel: command beats with key and value.
`timescale 1ns / 1ps
interface lhjt_in_if;
  logic                        valid;
  logic                        ready;
  logic [lhjt_pkg::CMD_W-1:0]  command;
  logic [lhjt_pkg::KEY_W-1:0]  key;
  logic [lhjt_pkg::VAL_W-1:0]  value;

  modport source (output valid, command, key, value, input ready);
  modport sink   (input valid, command, key, value, output ready);
endinterface

### src/lhjt_out_if.sv
// Result channel: one beat per result item.
`timescale 1ns / 1ps
interface lhjt_out_if;
  logic                          valid;
  logic                          ready;
  logic [lhjt_pkg::STATUS_W-1:0] status;
  logic [lhjt_pkg::VAL_W-1:0]    source_value;
  logic [lhjt_pkg::VAL_W-1:0]    matched_value;
  logic [lhjt_pkg::IDX_W-1:0]    match_index;
  logic                          last;

  modport source (output valid, status, source_value, matched_value, match_index, last,
                  input ready);
  modport sink   (input valid, status, source_value, matched_value, match_index, last,
                  output ready);
endinterface

### src/lhjt_cfg_if.sv
// Configuration write channel for the table size register.
`timescale 1ns / 1ps
interface lhjt_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lhjt_pkg::CFG_W-1:0] table_size_log2;

  modport source (output valid, table_size_log2, input ready);
  modport sink   (input valid, table_size_log2, output ready);
endinterface

### src/linear_probe_hash_join_table_core.sv
// Top level: linear probing hash table with a Murmur3-mixed slot index.
`timescale 1ns / 1ps
// Usage
//   in_s  : command beats (insert, probe, clear) with key and value; drop command 3.
//   out_m : result beats; insert, probe and clear give one or more, the final one has last set.
//   cfg_s : writes table_size_log2 (0 acts as 1, above 12 acts as 12); take it while idle.
// Timing
//   Insert and probe: hashing in S_MUL1, S_MUL2 and S_ADDR, then an S_CHECK
//   visit per slot in the table memory (one read port, one registered read each
//   cycle), then S_DONE to hand over the final beat. An insert landing on its
//   hashed slot shows its beat in the same cycle as in_s frees again; a probe
//   walks its cluster up to the first empty slot, a full sweep or the limit.
//   Clear: one slot written per cycle over all 4096 slots, then the result beat.
// Reset
//   A sweep writes every slot empty with in_s.ready low;
//   configuration writes are taken throughout. The size register resets to 12.
// Back-pressure
//   An output register holds one beat; a new command is taken while it waits.
//   Matches are held one behind so the last flag can be set; while out_m stalls
//   the walk holds on a matching slot and the final beat waits until it frees.
module linear_probe_hash_join_table_core (
  input  logic       clk,
  input  logic       rst_n,
  lhjt_in_if.sink    in_s,
  lhjt_out_if.source out_m,
  lhjt_cfg_if.sink   cfg_s
);

  localparam int AW = lhjt_pkg::TABLE_DEPTH_LOG2;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_INIT  = 8'b0000_0010,
    S_CLEAR = 8'b0000_0100,
    S_MUL1  = 8'b0000_1000,
    S_MUL2  = 8'b0001_0000,
    S_ADDR  = 8'b0010_0000,
    S_CHECK = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [lhjt_pkg::CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [lhjt_pkg::KEY_W-1:0]        key_r, key_nxt;
  logic [lhjt_pkg::VAL_W-1:0]        val_r, val_nxt;
  logic [lhjt_pkg::CFG_W-1:0]        lg_r, lg_nxt;
  logic [lhjt_pkg::CFG_W-1:0]        cfg_lg_r;
  logic [31:0]                       m1_r, m1_nxt;
  logic [31:0]                       m2_r, m2_nxt;
  logic [AW-1:0]                     pos_r, pos_nxt;
  logic [lhjt_pkg::SLOT_CNT_W-1:0]   n_r, n_nxt;
  logic [lhjt_pkg::IDX_W-1:0]        cnt_r, cnt_nxt;
  lhjt_pkg::status_t                 pend_status_r, pend_status_nxt;
  logic [lhjt_pkg::VAL_W-1:0]        pend_mv_r, pend_mv_nxt;
  logic [AW-1:0]                     clr_r, clr_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [lhjt_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [lhjt_pkg::VAL_W-1:0]        out_src_r, out_src_nxt;
  logic [lhjt_pkg::VAL_W-1:0]        out_mv_r, out_mv_nxt;
  logic [lhjt_pkg::IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic                              out_last_r, out_last_nxt;

  lhjt_pkg::slot_t                   mem [lhjt_pkg::DEPTH];
  lhjt_pkg::slot_t                   rd_r;
  lhjt_pkg::slot_t                   mem_wdata;
  logic [AW-1:0]                     mem_waddr;
  logic                              mem_we;

  logic                              load;
  logic                              in_acc;
  logic [31:0]                       h0, h1, h2;
  logic [AW-1:0]                     mask;
  logic                              swept;
  logic                              key_hit;
  logic [lhjt_pkg::IDX_W-1:0]        cnt_inc;

  assign in_s.ready  = (state_r == S_IDLE);
  assign cfg_s.ready = 1'b1;
  assign in_acc      = in_s.valid && in_s.ready;
  assign load        = !out_valid_r || out_m.ready;

  assign out_m.valid         = out_valid_r;
  assign out_m.status        = out_status_r;
  assign out_m.source_value  = out_src_r;
  assign out_m.matched_value = out_mv_r;
  assign out_m.match_index   = out_idx_r;
  assign out_m.last          = out_last_r;

  assign h0      = {1'b0, key_r} ^ ({1'b0, key_r} >> lhjt_pkg::MIX_SH_A);
  assign h1      = m1_r ^ (m1_r >> lhjt_pkg::MIX_SH_B);
  assign h2      = m2_r ^ (m2_r >> lhjt_pkg::MIX_SH_A);
  assign mask    = lhjt_pkg::slot_mask(lg_r);
  assign swept   = (n_r == (lhjt_pkg::SLOT_CNT_W'(1) << lg_r));
  assign key_hit = rd_r.vld && (rd_r.key == key_r);
  assign cnt_inc = cnt_r + lhjt_pkg::IDX_W'(1);

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    key_nxt         = key_r;
    val_nxt         = val_r;
    lg_nxt          = lg_r;
    m1_nxt          = m1_r;
    m2_nxt          = m2_r;
    pos_nxt         = pos_r;
    n_nxt           = n_r;
    cnt_nxt         = cnt_r;
    pend_status_nxt = pend_status_r;
    pend_mv_nxt     = pend_mv_r;
    clr_nxt         = clr_r;
    out_valid_nxt   = out_valid_r && !out_m.ready;
    out_status_nxt  = out_status_r;
    out_src_nxt     = out_src_r;
    out_mv_nxt      = out_mv_r;
    out_idx_nxt     = out_idx_r;
    out_last_nxt    = out_last_r;
    mem_we          = 1'b0;
    mem_waddr       = clr_r;
    mem_wdata       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt = in_s.command;
          key_nxt = in_s.key;
          val_nxt = in_s.value;
          if (cfg_lg_r == '0) begin
            lg_nxt = lhjt_pkg::CFG_W'(1);
          end else if (cfg_lg_r > lhjt_pkg::CFG_W'(AW)) begin
            lg_nxt = lhjt_pkg::CFG_W'(AW);
          end else begin
            lg_nxt = cfg_lg_r;
          end
          unique case (in_s.command)
            lhjt_pkg::CMD_INSERT, lhjt_pkg::CMD_PROBE: state_nxt = S_MUL1;
            lhjt_pkg::CMD_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INIT, S_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == '1) begin
          pend_status_nxt = lhjt_pkg::ST_CLEARED;
          pend_mv_nxt     = '0;
          cnt_nxt         = '0;
          state_nxt       = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_MUL1: begin
        m1_nxt    = h0 * lhjt_pkg::MIX_C1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        m2_nxt    = h1 * lhjt_pkg::MIX_C2;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        pos_nxt   = h2[AW-1:0] & mask;
        n_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (cmd_r == lhjt_pkg::CMD_INSERT) begin
          if (swept) begin
            pend_status_nxt = lhjt_pkg::ST_FULL;
            pend_mv_nxt     = '0;
            state_nxt       = S_DONE;
          end else if (!rd_r.vld) begin
            mem_we          = 1'b1;
            mem_waddr       = pos_r;
            mem_wdata       = '{vld: 1'b1, key: key_r, val: val_r};
            pend_status_nxt = lhjt_pkg::ST_INSERTED;
            pend_mv_nxt     = '0;
            state_nxt       = S_DONE;
          end else begin
            pos_nxt = (pos_r + AW'(1)) & mask;
            n_nxt   = n_r + lhjt_pkg::SLOT_CNT_W'(1);
          end
        end else begin
          if (swept || !rd_r.vld) begin
            if (cnt_r == '0) begin
              pend_status_nxt = lhjt_pkg::ST_NOMATCH;
              pend_mv_nxt     = '0;
            end
            state_nxt = S_DONE;
          end else if (key_hit) begin
            if (cnt_r == '0 || load) begin
              if (cnt_r != '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = lhjt_pkg::ST_MATCH;
                out_src_nxt    = val_r;
                out_mv_nxt     = pend_mv_r;
                out_idx_nxt    = cnt_r;
                out_last_nxt   = 1'b0;
              end
              cnt_nxt     = cnt_inc;
              pend_mv_nxt = rd_r.val;
              if (cnt_inc == lhjt_pkg::IDX_W'(lhjt_pkg::MAX_MATCHES)) begin
                pend_status_nxt = lhjt_pkg::ST_LIMIT;
                state_nxt       = S_DONE;
              end else begin
                pend_status_nxt = lhjt_pkg::ST_MATCH;
                pos_nxt         = (pos_r + AW'(1)) & mask;
                n_nxt           = n_r + lhjt_pkg::SLOT_CNT_W'(1);
              end
            end
          end else begin
            pos_nxt = (pos_r + AW'(1)) & mask;
            n_nxt   = n_r + lhjt_pkg::SLOT_CNT_W'(1);
          end
        end
      end
      S_DONE: begin
        if (load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_src_nxt    = (cmd_r == lhjt_pkg::CMD_PROBE) ? val_r : '0;
          out_mv_nxt     = pend_mv_r;
          out_idx_nxt    = cnt_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      cfg_lg_r    <= lhjt_pkg::CFG_W'(lhjt_pkg::CFG_RESET);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_s.valid && cfg_s.ready) begin
        cfg_lg_r <= cfg_s.table_size_log2;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    key_r         <= key_nxt;
    val_r         <= val_nxt;
    lg_r          <= lg_nxt;
    m1_r          <= m1_nxt;
    m2_r          <= m2_nxt;
    pos_r         <= pos_nxt;
    n_r           <= n_nxt;
    pend_status_r <= pend_status_nxt;
    pend_mv_r     <= pend_mv_nxt;
    out_status_r  <= out_status_nxt;
    out_src_r     <= out_src_nxt;
    out_mv_r      <= out_mv_nxt;
    out_idx_r     <= out_idx_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[pos_nxt];
  end

`ifndef ASSERT_OFF
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CHECK || state_r == S_INIT || state_r == S_CLEAR))
    else $error("table write outside insert or sweep");

  a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_CHECK) |-> !rd_r.vld)
    else $error("insert overwrote an occupied slot");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lhjt_pkg::IDX_W'(lhjt_pkg::MAX_MATCHES))
    else $error("match count beyond limit");

  a_limit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_m.valid && out_m.status == lhjt_pkg::ST_LIMIT) |->
      (out_m.last && out_m.match_index == lhjt_pkg::IDX_W'(lhjt_pkg::MAX_MATCHES)))
    else $error("match limit beat malformed");
`endif

endmodule
